### rtl/tccs_pkg.sv
// tccs_pkg: shared types and constants of the text console cursor/scroll engine
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package tccs_pkg;

   // fixed field widths of the channels
   localparam int COMMAND_W = 2;
   localparam int CODE_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int POS_W     = 11;
   localparam int CELL_W    = 16;
   localparam int GAP_W     = 5;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_SET   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CODE_W-1:0] CHAR_RETURN  = 8'd13;
   localparam logic [CODE_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CODE_W-1:0] CHAR_SPACE   = 8'h20;

   localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h0F;

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_EXEC   = 8'b0000_0100,
      ST_READ   = 8'b0000_1000,
      ST_SCR_RD = 8'b0001_0000,
      ST_SCR_WR = 8'b0010_0000,
      ST_FILL   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

### rtl/tccs_if.sv
// tccs channel interfaces: command request, result response and register write
// depends on tccs_pkg for the field widths
`default_nettype none

interface tccs_req_if;
   logic                          valid;
   logic                          ready;
   logic [tccs_pkg::COMMAND_W-1:0] command;
   logic [tccs_pkg::CODE_W-1:0]    char_code;
   logic [tccs_pkg::ATTR_W-1:0]    char_attribute;
   logic [tccs_pkg::COL_W-1:0]     target_column;
   logic [tccs_pkg::ROW_W-1:0]     target_row;

   modport source (output valid, command, char_code, char_attribute, target_column,
                   target_row, input ready);
   modport sink   (input valid, command, char_code, char_attribute, target_column,
                   target_row, output ready);
endinterface

interface tccs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tccs_pkg::POS_W-1:0]  cursor_position;
   logic [tccs_pkg::COL_W-1:0]  cursor_column;
   logic [tccs_pkg::ROW_W-1:0]  cursor_line;
   logic [tccs_pkg::CELL_W-1:0] cell_value;
   logic                       did_scroll;

   modport source (output valid, cursor_position, cursor_column, cursor_line, cell_value,
                   did_scroll, input ready);
   modport sink   (input valid, cursor_position, cursor_column, cursor_line, cell_value,
                   did_scroll, output ready);
endinterface

interface tccs_csr_if;
   logic                       valid;
   logic                       ready;
   logic [tccs_pkg::ATTR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/text_console_cursor_scroll.sv
// text_console_cursor_scroll: character-cell screen store with cursor, scroll and clear
// depends on tccs_pkg and the channel interfaces in tccs_if.sv
`default_nettype none

// Text console engine. A single-port-per-direction screen memory of COLUMNS*ROWS
// 16-bit cells (attribute high byte, character low byte) is driven by a small
// sequencer that shares one row*COLUMNS+column address unit. Commands are taken
// one at a time; read cell goes through a registered memory read, unless the
// target lies off the screen. A put character that runs past the bottom row
// scrolls the screen through the memory ports, each cell moved by a read state
// and then a write state, and then one blank row written at one cell a cycle.
// Clear screen writes one cell a cycle. After reset a clearing pass fills the
// screen with blanks; req_chan.ready stays low during it, register writes are
// taken at any time. A finished result waits in an output register, and the
// next command is accepted while it waits.
module text_console_cursor_scroll #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  wire           clock,
   input  wire           reset,
   tccs_req_if.sink      req_chan,
   tccs_rsp_if.source    rsp_chan,
   tccs_csr_if.sink      csr_chan
);
   import tccs_pkg::*;

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int MOVE_CNT  = (ROWS - 1) * COLUMNS;
   localparam int AW        = $clog2(CELLS);
   localparam int CW        = $clog2(COLUMNS);
   localparam int RW        = (ROWS > 2) ? $clog2(ROWS) : 1;
   localparam int CXW       = CW + GAP_W;
   localparam int LW        = (AW > POS_W) ? AW : POS_W;
   localparam int GAP_DEPTH = 1 << CW;

   state_type            state_ff, state_in;
   logic [AW-1:0]        ptr_ff, ptr_in;

   cmd_type              cmd_ff;
   logic [CODE_W-1:0]    code_ff;
   logic [ATTR_W-1:0]    attr_ff;
   logic [COL_W-1:0]     tcol_ff;
   logic [ROW_W-1:0]     trow_ff;

   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [ATTR_W-1:0]    blank_attr_ff;
   logic                 scroll_ff, scroll_in;
   logic [CELL_W-1:0]    cell_ff, cell_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic [COL_W-1:0]     rsp_col_ff;
   logic [ROW_W-1:0]     rsp_line_ff;
   logic [CELL_W-1:0]    rsp_cell_ff;
   logic                 rsp_scroll_ff;
   logic                 rsp_load;

   logic [CELL_W-1:0]    mem [CELLS];
   logic [CELL_W-1:0]    rd_data_ff;
   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [CELL_W-1:0]    mem_wdata;

   logic [LW-1:0]        mul_row, mul_col, lin;
   logic [GAP_W-1:0]     gap_lut [GAP_DEPTH];
   logic [CXW-1:0]       col_nx;
   logic [RW:0]          row_nx;
   logic                 target_ok;
   logic                 req_fire;
   logic [CELL_W-1:0]    blank_cell;

   // distance to the next tab stop for every column value
   for (genvar g = 0; g < GAP_DEPTH; g++) begin : g_gap
      assign gap_lut[g] = GAP_W'(TAB_STOP - (g % TAB_STOP));
   end

   assign blank_cell = {blank_attr_ff, CHAR_SPACE};
   assign target_ok  = (32'(tcol_ff) < COLUMNS) && (32'(trow_ff) < ROWS);
   assign req_fire   = req_chan.valid && req_chan.ready;

   // shared address unit: row * COLUMNS + column
   always_comb begin
      if (state_ff == ST_EXEC && cmd_ff == CMD_READ) begin
         mul_row = LW'(trow_ff);
         mul_col = LW'(tcol_ff);
      end else begin
         mul_row = LW'(row_ff);
         mul_col = LW'(col_ff);
      end
      lin = LW'(mul_row * LW'(COLUMNS)) + mul_col;
   end

   // cursor movement for a put character, with column wrap, before the scroll check
   always_comb begin
      col_nx = CXW'(col_ff);
      row_nx = {1'b0, row_ff};
      case (code_ff)
         CHAR_NEWLINE: begin
            col_nx = '0;
            row_nx = {1'b0, row_ff} + (RW+1)'(1);
         end
         CHAR_RETURN: begin
            col_nx = '0;
         end
         CHAR_TAB: begin
            col_nx = CXW'(col_ff) + CXW'(gap_lut[col_ff]);
         end
         default: begin
            col_nx = CXW'(col_ff) + CXW'(1);
         end
      endcase
      if (col_nx >= CXW'(COLUMNS)) begin
         col_nx = '0;
         row_nx = row_nx + (RW+1)'(1);
      end
   end

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      scroll_in = scroll_ff;
      cell_in   = cell_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = ptr_ff;
      mem_raddr = ptr_ff;
      mem_wdata = blank_cell;
      rsp_load  = 1'b0;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_INIT: begin
            // power-up fill always uses the reset attribute
            mem_we    = 1'b1;
            mem_wdata = {BLANK_ATTR_RESET, CHAR_SPACE};
            ptr_in    = ptr_ff + AW'(1);
            if (ptr_ff == AW'(CELLS - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            scroll_in      = 1'b0;
            cell_in        = '0;
            if (req_chan.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_PUT: begin
                  if (code_ff != CHAR_NEWLINE && code_ff != CHAR_RETURN &&
                      code_ff != CHAR_TAB) begin
                     mem_we    = 1'b1;
                     mem_waddr = lin[AW-1:0];
                     mem_wdata = {attr_ff, code_ff};
                  end
                  col_in = col_nx[CW-1:0];
                  if (row_nx >= (RW+1)'(ROWS)) begin
                     row_in    = RW'(ROWS - 1);
                     scroll_in = 1'b1;
                     ptr_in    = '0;
                     state_in  = ST_SCR_RD;
                  end else begin
                     row_in   = row_nx[RW-1:0];
                     state_in = ST_DONE;
                  end
               end
               CMD_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  ptr_in   = '0;
                  state_in = ST_FILL;
               end
               CMD_SET: begin
                  col_in   = (32'(tcol_ff) < COLUMNS) ? CW'(tcol_ff) : CW'(COLUMNS - 1);
                  row_in   = (32'(trow_ff) < ROWS) ? RW'(trow_ff) : RW'(ROWS - 1);
                  state_in = ST_DONE;
               end
               CMD_READ: begin
                  if (target_ok) begin
                     mem_re    = 1'b1;
                     mem_raddr = lin[AW-1:0];
                     state_in  = ST_READ;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_READ: begin
            cell_in  = rd_data_ff;
            state_in = ST_DONE;
         end
         // move one cell up a row: read below, then write
         ST_SCR_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_ff + AW'(COLUMNS);
            state_in  = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            ptr_in    = ptr_ff + AW'(1);
            state_in  = (ptr_ff == AW'(MOVE_CNT - 1)) ? ST_FILL : ST_SCR_RD;
         end
         ST_FILL: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + AW'(1);
            if (ptr_ff == AW'(CELLS - 1)) begin
               ptr_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         ptr_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         scroll_ff     <= 1'b0;
         cell_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         blank_attr_ff <= BLANK_ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         scroll_ff    <= scroll_in;
         cell_ff      <= cell_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            blank_attr_ff <= csr_chan.data;
         end
      end
   end

   // captured command and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= cmd_type'(req_chan.command);
         code_ff <= req_chan.char_code;
         attr_ff <= req_chan.char_attribute;
         tcol_ff <= req_chan.target_column;
         trow_ff <= req_chan.target_row;
      end
      if (rsp_load) begin
         rsp_pos_ff    <= lin[POS_W-1:0];
         rsp_col_ff    <= COL_W'(col_ff);
         rsp_line_ff   <= ROW_W'(row_ff);
         rsp_cell_ff   <= cell_ff;
         rsp_scroll_ff <= scroll_ff;
      end
   end

   // screen memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign csr_chan.ready           = 1'b1;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.cursor_position = rsp_pos_ff;
   assign rsp_chan.cursor_column   = rsp_col_ff;
   assign rsp_chan.cursor_line     = rsp_line_ff;
   assign rsp_chan.cell_value      = rsp_cell_ff;
   assign rsp_chan.did_scroll      = rsp_scroll_ff;

endmodule

`default_nettype wire

### rtl/tccs_checker.sv
// tccs_checker: port-level assertions on the console result channel, with its bind
// depends on tccs_pkg; attaches to text_console_cursor_scroll
`default_nettype none

module tccs_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire [tccs_pkg::POS_W-1:0]      position,
   input wire [tccs_pkg::COL_W-1:0]      column,
   input wire [tccs_pkg::ROW_W-1:0]      line,
   input wire [tccs_pkg::CELL_W-1:0]     cell_data,
   input wire                            scroll
);
   import tccs_pkg::*;

   localparam bit FIELDS_FIT = (COLUMNS <= 128) && (ROWS <= 32);

   // a stalled transaction keeps its valid
   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // a stalled transaction keeps its payload
   a_payload_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(position) && $stable(column) && $stable(line)
                                  && $stable(cell_data) && $stable(scroll))
      else $error("result payload changed while stalled");

   // linear position agrees with column and line
   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && FIELDS_FIT |->
         position == POS_W'(32'(line) * COLUMNS + 32'(column)))
      else $error("cursor position does not match column and line");

   // a scroll leaves the cursor on the bottom line and reads no cell
   a_scroll_bottom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && scroll && FIELDS_FIT |-> line == ROW_W'(ROWS - 1) && cell_data == '0)
      else $error("scroll result not on bottom line");

endmodule

bind text_console_cursor_scroll tccs_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tccs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .position  (rsp_chan.cursor_position),
   .column    (rsp_chan.cursor_column),
   .line      (rsp_chan.cursor_line),
   .cell_data (rsp_chan.cell_value),
   .scroll    (rsp_chan.did_scroll)
);

`default_nettype wire
